// ===== hw/rtl/bitset_pkg.sv =====
// ============================================================================
// bitset_pkg
// Shared types, constants and helpers for the bit store with range query.
// ============================================================================
package bitset_pkg;

    localparam int MAX_BITS    = 4096;
    localparam int WORD_BITS   = 32;
    localparam int TOTAL_WORDS = MAX_BITS / WORD_BITS;
    localparam int ADDR_W      = $clog2(TOTAL_WORDS);
    localparam int POS_W       = $clog2(WORD_BITS);
    localparam int CNT_W       = $clog2(TOTAL_WORDS + 1);
    localparam int IDX_W       = 12;
    localparam int END_W       = 13;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_GET   = 2'd1,
        OP_SET   = 2'd2,
        OP_ANY   = 2'd3
    } opcode_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic eval;
        logic step;
        logic wr_en;
        logic load_out;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t in_op;
        logic    in_err;
        logic    in_empty;
        opcode_t op;
        logic    hit;
        logic    last_word;
        logic    out_free;
    } dp_status_t;

    // Bits lo..hi of a word in index order; index k sits at position WORD_BITS-1-k
    function automatic logic [WORD_BITS-1:0] range_mask(input logic [POS_W-1:0] lo,
                                                        input logic [POS_W-1:0] hi);
        logic [WORD_BITS-1:0] m;
        logic [POS_W-1:0]     k;
        for (int p = 0; p < WORD_BITS; p++) begin
            k    = POS_W'(WORD_BITS - 1 - p);
            m[p] = (k >= lo) && (k <= hi);
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/bitset_ram.sv =====
// ============================================================================
// bitset_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
module bitset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bitset_dp.sv =====
// ============================================================================
// bitset_dp
// Datapath: operand latches, word store with per-word valid bits, range
// check, word walk pointer, bit masking and the output register.
// ============================================================================
module bitset_dp
    import bitset_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser
);

    logic [IDX_W-1:0] in_idx;
    logic [END_W-1:0] in_right;
    logic             in_nv;
    opcode_t          in_op;
    logic [END_W-1:0] in_rm1;
    logic [END_W-1:0] lim;
    logic             in_err;

    opcode_t          op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             nv_reg;
    logic             err_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] last_word_reg;
    logic [POS_W-1:0]  last_pos_reg;
    logic             found_reg;
    logic [CNT_W-1:0] words_reg;
    logic [TOTAL_WORDS-1:0] valid_reg;
    logic             rvalid_reg;

    logic             m_tvalid_reg;
    logic             m_answer_reg;
    logic             m_kind_reg;
    logic             m_err_reg;

    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] wr_data;
    logic [POS_W-1:0]     bit_pos;
    logic [POS_W-1:0]     lo;
    logic [POS_W-1:0]     hi;
    logic                 last_word;
    logic                 hit;

    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_right = s_tdata[IDX_W+END_W-1:IDX_W];
    assign in_nv    = s_tdata[IDX_W+END_W];
    assign in_op    = opcode_t'(s_tuser);
    assign in_rm1   = in_right - END_W'(1);
    assign lim      = {words_reg, {POS_W{1'b0}}};

    always_comb begin
        case (in_op)
            OP_GET, OP_SET: in_err = ({1'b0, in_idx} >= lim);
            OP_ANY:         in_err = ({1'b0, in_idx} > in_right) || (in_right > lim);
            default:        in_err = 1'b0;
        endcase
    end

    // word store
    bitset_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TOTAL_WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // words never written since the last clear read as zero
    assign word_q  = rvalid_reg ? rd_data : '0;
    assign bit_pos = POS_W'(WORD_BITS - 1) - idx_reg[POS_W-1:0];
    assign wr_data = (word_q & ~(WORD_BITS'(1) << bit_pos))
                   | (WORD_BITS'(nv_reg) << bit_pos);

    assign last_word = (ptr_reg == last_word_reg);
    assign lo  = (ptr_reg == idx_reg[IDX_W-1:POS_W]) ? idx_reg[POS_W-1:0] : '0;
    assign hi  = last_word ? last_pos_reg : '1;
    assign hit = |(word_q & range_mask(lo, hi));

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg        <= in_op;
            idx_reg       <= in_idx;
            nv_reg        <= in_nv;
            err_reg       <= in_err;
            ptr_reg       <= in_idx[IDX_W-1:POS_W];
            last_word_reg <= in_rm1[IDX_W-1:POS_W];
            last_pos_reg  <= in_rm1[POS_W-1:0];
        end else if (cmd.step) begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
        if (cmd.rd_en) begin
            rvalid_reg <= valid_reg[ptr_reg];
        end
        if (cmd.accept) begin
            found_reg <= 1'b0;
        end else if (cmd.eval) begin
            found_reg <= (op_reg == OP_GET) ? word_q[bit_pos] : hit;
        end
        if (cmd.load_out) begin
            m_answer_reg <= found_reg;
            m_kind_reg   <= (op_reg == OP_ANY);
            m_err_reg    <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg    <= CNT_W'(TOTAL_WORDS);
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.accept && in_op == OP_CLEAR) begin
                valid_reg <= '0;
                words_reg <= CNT_W'(in_idx[IDX_W-1:POS_W]) + CNT_W'(1);
            end else if (cmd.wr_en) begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.in_op     = in_op;
    assign status.in_err    = in_err;
    assign status.in_empty  = ({1'b0, in_idx} == in_right);
    assign status.op        = op_reg;
    assign status.hit       = hit;
    assign status.last_word = last_word;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_answer_reg};
    assign m_tuser  = {m_err_reg, m_kind_reg};

endmodule

// ===== hw/rtl/bitset_ctrl.sv =====
// ============================================================================
// bitset_ctrl
// Controller: takes one transaction, sequences store reads, the word walk
// of a range query, the write-back of a set and the hand-off to the output.
// ============================================================================
module bitset_ctrl
    import bitset_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    case (status.in_op)
                        OP_CLEAR: state_next = ST_IDLE;
                        OP_SET:   state_next = status.in_err ? ST_IDLE : ST_READ;
                        OP_GET:   state_next = status.in_err ? ST_DONE : ST_READ;
                        OP_ANY:   state_next = (status.in_err || status.in_empty) ?
                                               ST_DONE : ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                case (status.op)
                    OP_SET: begin
                        cmd.wr_en  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_GET: state_next = ST_DONE;
                    OP_ANY: begin
                        if (status.hit || status.last_word) begin
                            state_next = ST_DONE;
                        end else begin
                            cmd.step   = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/bitset_get_set_range_any_top.sv =====
// ============================================================================
// bitset_get_set_range_any_top
// 4096-bit store of 32-bit words: clear-and-size, get, set, range-any.
// ============================================================================
// Usage:
//  - s_ channel: one operation per transaction, opcode in s_tuser. Clear and
//    set give no result; get and any each give one result transaction on m_.
//  - Clear completes when taken (valid bits drop at once); set reads the
//    word and writes it back. A get reads the word, tests the bit and loads
//    the result register, which raises m_tvalid. Any walks the range word by
//    word, stopping at the first word holding a set bit in range or at the
//    last word, with one store read per word (read, then mask and test).
//  - An out-of-range or inverted request is answered at once with
//    range_error set and answer 0; an out-of-range set is dropped.
//  - Reset empties the store and makes all 128 words usable; no clearing
//    pass is needed.
//  - A result waits in the output register while m_tready is low; the next
//    transaction is still taken and worked on, and holds only at the point
//    where its own result must be loaded.
// ============================================================================
module bitset_get_set_range_any_top
    import bitset_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index[11:0], right_end[24:12], new_value[25]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // answer[0]
    output logic [1:0]  m_tuser    // answer_kind[0], range_error[1]
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bitset_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bitset_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hw/rtl/bitset_checker.sv =====
// ============================================================================
// bitset_checker
// Port-level checks for the bit store, bound to the top level.
// ============================================================================
module bitset_checker
    import bitset_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an error result never reports a hit or a set bit
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tdata[0])
        else $error("range error with answer set");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'd0))
        else $error("padding bits of m_tdata not zero");

    // clear completes in the cycle it is taken
    a_clear_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_CLEAR) |=> s_tready)
        else $error("not ready after clear");

    // a get always produces a result, so the block is busy afterwards
    a_get_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_GET) |=> !s_tready)
        else $error("ready straight after get");

endmodule

bind bitset_get_set_range_any_top bitset_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the bit store with get, set, clear-and-size and
// range-any. A mirror of the store predicts every get and any answer at the
// point each s_ transaction is taken; m_ transactions are checked in order.
// ============================================================================
module testbench;
    import bitset_pkg::*;

    typedef struct {
        logic answer;
        logic kind;
        logic err;
    } answer_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    opcode_t     s_tuser  = OP_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    // mirror of the block's state
    logic [WORD_BITS-1:0] store_words [TOTAL_WORDS];
    int                   words_used;
    answer_t              answers_q [$];

    int mismatch_count = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_left      = 0;

    bitset_get_set_range_any_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic stored_bit(input int i);
        return store_words[i / WORD_BITS][WORD_BITS - 1 - (i % WORD_BITS)];
    endfunction

    // update the mirror and queue the answer the block owes, if any
    task automatic predict_op(input opcode_t op, input int idx, input int right,
                              input logic nv);
        int      lim;
        answer_t a;
        lim = words_used * WORD_BITS;
        case (op)
            OP_CLEAR: begin
                words_used = idx / WORD_BITS + 1;
                if (words_used > TOTAL_WORDS) words_used = TOTAL_WORDS;
                foreach (store_words[w]) store_words[w] = '0;
            end
            OP_SET: begin
                if (idx < lim) begin
                    store_words[idx / WORD_BITS][WORD_BITS - 1 - (idx % WORD_BITS)] = nv;
                end
            end
            OP_GET: begin
                a.kind   = 1'b0;
                a.err    = (idx >= lim);
                a.answer = a.err ? 1'b0 : stored_bit(idx);
                answers_q.push_back(a);
            end
            default: begin
                a.kind   = 1'b1;
                a.err    = (idx > right) || (right > lim);
                a.answer = 1'b0;
                if (!a.err) begin
                    for (int i = idx; i < right && !a.answer; i++) a.answer = stored_bit(i);
                end
                answers_q.push_back(a);
            end
        endcase
    endtask

    // one s_ transaction; valid stays high afterwards unless the next call idles
    task automatic send_op(input opcode_t op, input int idx, input int right,
                           input logic nv);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, nv, right[END_W-1:0], idx[IDX_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        predict_op(op, idx, right, nv);
    endtask

    // drop valid first so the last transaction is not taken twice
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answers_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, or a counted hold-off when one is asked for
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_q.size() == 0) begin
                $display("%0t: unexpected result answer=%0b kind=%0b err=%0b",
                         $time, m_tdata[0], m_tuser[0], m_tuser[1]);
                mismatch_count++;
            end else begin
                want = answers_q.pop_front();
                if (m_tdata[0] !== want.answer) begin
                    $display("%0t: answer expected %0b got %0b", $time, want.answer, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.kind) begin
                    $display("%0t: answer_kind expected %0b got %0b", $time, want.kind, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.err) begin
                    $display("%0t: range_error expected %0b got %0b", $time, want.err, m_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom_range(0, 4095);
        if (r < 60) return $urandom_range(0, words_used * WORD_BITS - 1);
        return $urandom_range(0, 95);   // hot window so gets and anys meet set bits
    endfunction

    task automatic random_op(input bit reads_only);
        int   r;
        int   idx;
        int   right;
        logic nv;
        r     = reads_only ? $urandom_range(40, 99) : $urandom_range(0, 99);
        idx   = pick_index();
        nv    = ($urandom_range(0, 9) < 7);
        right = $urandom_range(0, 8191);
        if (r < 4) begin
            if ($urandom_range(0, 9) < 7) idx = $urandom_range(3000, 4095);
            send_op(OP_CLEAR, idx, right, nv);
        end else if (r < 40) begin
            send_op(OP_SET, idx, right, nv);
        end else if (r < 70) begin
            send_op(OP_GET, idx, right, nv);
        end else begin
            r = $urandom_range(0, 9);
            if (r < 8)       right = idx + $urandom_range(0, 64);
            else if (r == 8) right = words_used * WORD_BITS;
            send_op(OP_ANY, idx, right & 13'h1fff, nv);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_op(OP_GET, 0, 0, 1'b0);
        send_op(OP_GET, 4095, 8191, 1'b1);
        send_op(OP_ANY, 0, 4096, 1'b0);
    endtask

    task automatic test_set_get_extremes();
        send_op(OP_SET, 0, 0, 1'b1);
        send_op(OP_SET, 4095, 8191, 1'b1);
        send_op(OP_SET, 4094, 0, 1'b0);
        send_op(OP_GET, 0, 0, 1'b0);
        send_op(OP_GET, 4095, 0, 1'b0);
        send_op(OP_SET, 0, 0, 1'b0);
        send_op(OP_GET, 0, 0, 1'b1);
    endtask

    task automatic test_any_ranges();
        send_op(OP_ANY, 1, 4095, 1'b0);
        send_op(OP_ANY, 4095, 4096, 1'b0);
        send_op(OP_ANY, 5, 5, 1'b0);        // empty range
        send_op(OP_ANY, 10, 5, 1'b0);       // inverted
        send_op(OP_ANY, 0, 8191, 1'b1);     // beyond the store
    endtask

    task automatic test_clear_sizing();
        send_op(OP_CLEAR, 0, 0, 1'b0);      // one word usable
        send_op(OP_GET, 32, 0, 1'b0);
        send_op(OP_SET, 40, 0, 1'b1);       // dropped
        send_op(OP_ANY, 0, 33, 1'b0);
        send_op(OP_SET, 31, 0, 1'b1);
        send_op(OP_ANY, 0, 32, 1'b0);
        send_op(OP_GET, 31, 0, 1'b0);
        send_op(OP_CLEAR, 4095, 0, 1'b0);   // full size again
    endtask

    task automatic test_random_traffic();
        int phase_idle  [4] = '{0, 64, 0, 28};
        int phase_stall [4] = '{0, 0, 64, 28};
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (240) random_op(1'b0);
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps going, so the block backs up
    task automatic test_backpressure();
        hold_left = 400;
        repeat (40) random_op(1'b1);
    endtask

    task automatic test_drain_pause();
        repeat (12) random_op(1'b0);
        wait_for_results();
        repeat (12) random_op(1'b0);
    endtask

    initial begin
        foreach (store_words[w]) store_words[w] = '0;
        words_used = TOTAL_WORDS;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_set_get_extremes();
        test_any_ranges();
        test_clear_sizing();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();

        wait_for_results();
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bitset_pkg.sv
hw/rtl/bitset_ram.sv
hw/rtl/bitset_dp.sv
hw/rtl/bitset_ctrl.sv
hw/rtl/bitset_get_set_range_any_top.sv
hw/rtl/bitset_checker.sv
sim/testbench.sv
